FILE: rtl/bfn_pkg.sv
// ----------------------------------------------------------------------------
// bfn_pkg
// Shared types and constants for the bitmap find-next block.
// ----------------------------------------------------------------------------
package bfn_pkg;

    localparam int WORD_W = 32;   // bitmap bits held in one memory word
    localparam int OFF_W  = 5;    // bit offset within a word
    localparam int IDX_W  = 10;   // request and result index width
    localparam int CNT_W  = 11;   // bit_count register width
    localparam int LIM_W  = 17;   // wide enough for any bit position up to 65536

    localparam logic [2:0] REQ_GET        = 3'd0;
    localparam logic [2:0] REQ_SET        = 3'd1;
    localparam logic [2:0] REQ_CLEAR      = 3'd2;
    localparam logic [2:0] REQ_FIND_CLEAR = 3'd3;
    localparam logic [2:0] REQ_FIND_SET   = 3'd4;

    localparam logic [CNT_W-1:0] BIT_COUNT_RESET = 11'd1024;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EXEC
    } state_t;

endpackage

FILE: rtl/bfn_ram.sv
// ----------------------------------------------------------------------------
// bfn_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module bfn_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                                      clk,
    input  logic                                      we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                          wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                          rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: rtl/bitmap_find_next.sv
// Get, set and clear each pass through EXEC once; done is registered from it.
// busy is high until a request is through, so no new one is taken meanwhile; a find
// scans the map in EXEC, one 32-bit memory word per cycle.
// Reset: the bitmap memory is swept to zero, one word per cycle, and busy stays
// high meanwhile. bit_count resets to 1024.
// The receiver cannot stall: each result is shown for one cycle with done.
// ----------------------------------------------------------------------------
// bitmap_find_next
// Bit allocator bitmap: get, set and clear single bits, and find the next
// clear or set bit at or above a start index, below the bit_count boundary.
// ----------------------------------------------------------------------------
module bitmap_find_next #(
    parameter int MAP_BITS = 1024
) (
    input  logic                      clk,
    input  logic                      rst_n,
    // configuration
    input  logic                      bit_count_we,
    input  logic [bfn_pkg::CNT_W-1:0] bit_count,
    // request transaction
    input  logic                      start,
    output logic                      busy,
    input  logic [2:0]                req_type,
    input  logic [bfn_pkg::IDX_W-1:0] bit_index,
    // result transaction
    output logic                      done,
    output logic                      bit_value,
    output logic                      found,
    output logic [bfn_pkg::IDX_W-1:0] found_index
);

    localparam int WORDS = (MAP_BITS + bfn_pkg::WORD_W - 1) / bfn_pkg::WORD_W;
    localparam int AW    = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam int CW    = AW + 1;   // word counter, can hold WORDS itself
    localparam int LW    = bfn_pkg::LIM_W;
    localparam int WW    = bfn_pkg::WORD_W;
    localparam int OW    = bfn_pkg::OFF_W;
    localparam int IW    = bfn_pkg::IDX_W;

    bfn_pkg::state_t state_reg, state_next;

    logic [bfn_pkg::CNT_W-1:0] bit_count_reg;
    logic [CW-1:0]             clr_reg, clr_next;
    logic [CW-1:0]             word_reg, word_next;
    logic [OW-1:0]             off_reg, off_next;
    logic [2:0]                req_reg, req_next;
    logic [IW-1:0]             idx_reg, idx_next;

    logic                      done_reg, done_next;
    logic                      bit_value_reg, bit_value_next;
    logic                      found_reg, found_next;
    logic [IW-1:0]             found_index_reg, found_index_next;

    // memory ports
    logic                      mem_we;
    logic [AW-1:0]             mem_waddr;
    logic [WW-1:0]             mem_wdata;
    logic [AW-1:0]             mem_raddr;
    logic [WW-1:0]             mem_rdata;

    // datapath terms
    logic [LW-1:0]             lim;
    logic [LW-1:0]             base;
    logic [LW-1:0]             base_after;
    logic [LW-1:0]             rem;
    logic                      in_range;
    logic [WW-1:0]             lim_mask;
    logic [WW-1:0]             lo_mask;
    logic [WW-1:0]             cand;
    logic [WW-1:0]             bit_sel;
    logic [OW-1:0]             hit_pos;
    logic [CW-1:0]             start_word;
    logic                      scan_more;
    logic                      clr_last;

    bfn_ram #(
        .WIDTH (WW),
        .DEPTH (WORDS)
    ) u_map_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // Effective boundary: bit_count saturated to the map size.
    assign lim = (LW'(bit_count_reg) > LW'(MAP_BITS)) ? LW'(MAP_BITS)
                                                      : LW'(bit_count_reg);

    assign base       = LW'(word_reg) << OW;
    assign base_after = base + LW'(WW);
    assign rem        = lim - base;
    assign in_range   = LW'(idx_reg) < lim;
    assign start_word = CW'(LW'(bit_index) >> OW);
    assign clr_last   = (clr_reg == CW'(WORDS - 1));

    // Bits of the current word that lie below the boundary, and at or above
    // the start offset.
    assign lim_mask = (rem >= LW'(WW)) ? '1 : ((WW'(1) << rem[OW-1:0]) - WW'(1));
    assign lo_mask  = '1 << off_reg;
    assign bit_sel  = WW'(1) << off_reg;
    assign cand     = ((req_reg == bfn_pkg::REQ_FIND_SET) ? mem_rdata : ~mem_rdata)
                      & lo_mask & lim_mask;

    // Lowest matching bit in the word.
    always_comb
    begin
        hit_pos = '0;
        for (int j = WW - 1; j >= 0; j--)
        begin
            if (cand[j])
            begin
                hit_pos = OW'(j);
            end
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            bfn_pkg::ST_CLEAR:
            begin
                if (clr_last)
                begin
                    state_next = bfn_pkg::ST_IDLE;
                end
            end
            bfn_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    state_next = bfn_pkg::ST_EXEC;
                end
            end
            bfn_pkg::ST_EXEC:
            begin
                if (!scan_more)
                begin
                    state_next = bfn_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = bfn_pkg::ST_IDLE;
            end
        endcase
    end

    // Outputs and datapath
    always_comb
    begin
        clr_next         = clr_reg;
        word_next        = word_reg;
        off_next         = off_reg;
        req_next         = req_reg;
        idx_next         = idx_reg;
        done_next        = 1'b0;
        bit_value_next   = 1'b0;
        found_next       = 1'b0;
        found_index_next = '0;
        mem_we           = 1'b0;
        mem_waddr        = AW'(word_reg);
        mem_wdata        = mem_rdata;
        mem_raddr        = AW'(word_reg);
        scan_more        = 1'b0;
        busy             = 1'b1;

        case (state_reg)
            bfn_pkg::ST_CLEAR:
            begin
                // sweep the map to zero
                mem_we    = 1'b1;
                mem_waddr = AW'(clr_reg);
                mem_wdata = '0;
                clr_next  = clr_reg + CW'(1);
            end
            bfn_pkg::ST_IDLE:
            begin
                busy      = 1'b0;
                mem_raddr = AW'(start_word);
                if (start)
                begin
                    req_next  = req_type;
                    idx_next  = bit_index;
                    word_next = start_word;
                    off_next  = bit_index[OW-1:0];
                end
            end
            bfn_pkg::ST_EXEC:
            begin
                case (req_reg)
                    bfn_pkg::REQ_GET:
                    begin
                        done_next      = 1'b1;
                        bit_value_next = in_range & |(mem_rdata & bit_sel);
                    end
                    bfn_pkg::REQ_SET:
                    begin
                        done_next = 1'b1;
                        mem_we    = in_range;
                        mem_wdata = mem_rdata | bit_sel;
                    end
                    bfn_pkg::REQ_CLEAR:
                    begin
                        done_next = 1'b1;
                        mem_we    = in_range;
                        mem_wdata = mem_rdata & ~bit_sel;
                    end
                    bfn_pkg::REQ_FIND_CLEAR,
                    bfn_pkg::REQ_FIND_SET:
                    begin
                        if (!in_range)
                        begin
                            done_next = 1'b1;
                        end
                        else if (cand != '0)
                        begin
                            done_next        = 1'b1;
                            found_next       = 1'b1;
                            found_index_next = IW'(base + LW'(hit_pos));
                        end
                        else if (base_after >= lim)
                        begin
                            // ran off the boundary: report not found
                            done_next = 1'b1;
                        end
                        else
                        begin
                            // advance to the next word, offset restarts at zero
                            scan_more = 1'b1;
                            word_next = word_reg + CW'(1);
                            off_next  = '0;
                            mem_raddr = AW'(word_reg + CW'(1));
                        end
                    end
                    default:
                    begin
                        done_next = 1'b1;
                    end
                endcase
            end
            default:
            begin
                busy = 1'b1;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= bfn_pkg::ST_CLEAR;
            clr_reg       <= '0;
            bit_count_reg <= bfn_pkg::BIT_COUNT_RESET;
            done_reg      <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            done_reg  <= done_next;
            if (bit_count_we)
            begin
                bit_count_reg <= bit_count;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        word_reg        <= word_next;
        off_reg         <= off_next;
        req_reg         <= req_next;
        idx_reg         <= idx_next;
        bit_value_reg   <= bit_value_next;
        found_reg       <= found_next;
        found_index_reg <= found_index_next;
    end

    assign done        = done_reg;
    assign bit_value   = bit_value_reg;
    assign found       = found_reg;
    assign found_index = found_index_reg;

endmodule

FILE: bench/bitmap_find_next_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// bitmap_find_next_test
// Self-checking bench for the bitmap find-next block. A short scripted table
// covers reset contents, the ends of the index range, every request code and
// the boundary cases. Random phases follow, each under its own bit_count
// setting, and mix runs of sets or clears with searches across those runs.
// Every result is checked against a bit-level bitmap shadow or a typed-in reply.
// ----------------------------------------------------------------------------
module bitmap_find_next_test;

    localparam int MAP_BITS      = 1024;
    localparam int HALF_PERIOD   = 4;      // 8 ns clock
    localparam int RESET_CYCLES  = 10;
    localparam int SETTLE_CYCLES = 4;      // quiet time before a bit_count write
    localparam int TAIL_CYCLES   = 40;
    localparam int STALL_LIMIT   = 2000;   // cycles with no transaction at all
    localparam int REPORT_LIMIT  = 10;
    localparam int KEEP_LIMIT    = -1;     // script row leaves bit_count alone

    // Request codes the block does not define; they must change nothing.
    localparam logic [2:0] REQ_SPARE_A = 3'd5;
    localparam logic [2:0] REQ_SPARE_B = 3'd6;
    localparam logic [2:0] REQ_SPARE_C = 3'd7;

    typedef enum bit {
        BY_MODEL,   // expectation comes from the shadow bitmap
        BY_TABLE    // expectation is typed into the script row
    } reply_source_t;

    typedef struct packed {
        logic                      bit_value;
        logic                      found;
        logic [bfn_pkg::IDX_W-1:0] found_index;
    } bitmap_reply_t;

    typedef struct packed {
        logic                      change_limit;
        logic [bfn_pkg::CNT_W-1:0] limit_value;
        logic [2:0]                kind;
        logic [bfn_pkg::IDX_W-1:0] idx;
        reply_source_t             source;
        bitmap_reply_t             reply;
    } script_row_t;

    // ------------------------------------------------------------------------
    // DUT connections
    // ------------------------------------------------------------------------
    logic                      clk = 1'b0;
    logic                      rst_n;
    logic                      bit_count_we;
    logic [bfn_pkg::CNT_W-1:0] bit_count;
    logic                      start;
    logic                      busy;
    logic [2:0]                req_type;
    logic [bfn_pkg::IDX_W-1:0] bit_index;
    logic                      done;
    logic                      bit_value;
    logic                      found;
    logic [bfn_pkg::IDX_W-1:0] found_index;

    bitmap_find_next #(
        .MAP_BITS(MAP_BITS)
    ) DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .bit_count_we(bit_count_we),
        .bit_count   (bit_count),
        .start       (start),
        .busy        (busy),
        .req_type    (req_type),
        .bit_index   (bit_index),
        .done        (done),
        .bit_value   (bit_value),
        .found       (found),
        .found_index (found_index)
    );

    always
    begin
        #(HALF_PERIOD) clk = 1'b1;
        #(HALF_PERIOD) clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Shadow state and bookkeeping
    // ------------------------------------------------------------------------
    logic [MAP_BITS-1:0]       map_shadow;
    logic [bfn_pkg::CNT_W-1:0] limit_shadow;
    bitmap_reply_t             expected_replies[$];
    script_row_t               script[$];

    int unsigned failures;
    int unsigned results_checked;
    int unsigned kind_seen [0:7];
    int unsigned finds_located;
    int unsigned limits_used;
    int unsigned burst_left;
    int unsigned stall_cycles;

    // Boundary in force: bit_count saturated to the bitmap size.
    function automatic int unsigned active_limit();
        return (limit_shadow > MAP_BITS) ? MAP_BITS : int'(limit_shadow);
    endfunction

    // Apply one request to the shadow bitmap and return the reply it earns.
    function automatic bitmap_reply_t resolve_request(
        input logic [2:0]                kind,
        input logic [bfn_pkg::IDX_W-1:0] idx);
        bitmap_reply_t r;
        int unsigned   lim;
        logic          want;
        r    = '0;
        lim  = active_limit();
        want = (kind == bfn_pkg::REQ_FIND_SET);
        case (kind)
            bfn_pkg::REQ_GET:
                if (idx < lim)
                    r.bit_value = map_shadow[idx];
            bfn_pkg::REQ_SET:
                if (idx < lim)
                    map_shadow[idx] = 1'b1;
            bfn_pkg::REQ_CLEAR:
                if (idx < lim)
                    map_shadow[idx] = 1'b0;
            bfn_pkg::REQ_FIND_CLEAR, bfn_pkg::REQ_FIND_SET:
                // search upward, never at or past the boundary
                for (int unsigned i = idx; i < lim; i++)
                begin
                    if (!r.found && map_shadow[i] == want)
                    begin
                        r.found       = 1'b1;
                        r.found_index = bfn_pkg::IDX_W'(i);
                    end
                end
            default:
                ;
        endcase
        return r;
    endfunction

    // Index mostly inside the boundary, with its ends and the full range mixed in.
    function automatic logic [bfn_pkg::IDX_W-1:0] pick_index(input int unsigned lim);
        int unsigned roll;
        roll = $urandom_range(0, 9);
        if (lim == 0 || roll == 2)
            return bfn_pkg::IDX_W'($urandom_range(0, MAP_BITS - 1));
        if (roll == 0)
            return '0;
        if (roll == 1)
            return bfn_pkg::IDX_W'(lim - 1);
        return bfn_pkg::IDX_W'($urandom_range(0, lim - 1));
    endfunction

    task automatic add_step(input int limit, input logic [2:0] kind, input int idx,
                            input reply_source_t source, input logic bv,
                            input logic fd, input int fi);
        script_row_t row;
        row.change_limit      = (limit != KEEP_LIMIT);
        row.limit_value       = bfn_pkg::CNT_W'(limit);
        row.kind              = kind;
        row.idx               = bfn_pkg::IDX_W'(idx);
        row.source            = source;
        row.reply.bit_value   = bv;
        row.reply.found       = fd;
        row.reply.found_index = bfn_pkg::IDX_W'(fi);
        script.push_back(row);
    endtask

    // ------------------------------------------------------------------------
    // Request driver: present one transaction and hold it until the block
    // takes it. The sender works in bursts; when a burst runs out, drop start
    // for a random gap (or skip the gap now and then for back-to-back traffic).
    // ------------------------------------------------------------------------
    task automatic send_request(input logic [2:0] kind,
                                input logic [bfn_pkg::IDX_W-1:0] idx,
                                input reply_source_t source,
                                input bitmap_reply_t table_reply);
        bitmap_reply_t predicted;
        int unsigned   gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 40);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap != 0)
            begin
                start <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        start     <= 1'b1;
        req_type  <= kind;
        bit_index <= idx;
        // busy is sampled as it stood before this edge
        do @(posedge clk); while (busy !== 1'b0);
        predicted = resolve_request(kind, idx);
        expected_replies.push_back((source == BY_TABLE) ? table_reply : predicted);
        kind_seen[kind]++;
        if (predicted.found)
            finds_located++;
        burst_left--;
    endtask

    // Drop start and wait until every outstanding result is back.
    task automatic settle();
        start <= 1'b0;
        while (expected_replies.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_limit(input logic [bfn_pkg::CNT_W-1:0] value);
        bit_count_we <= 1'b1;
        bit_count    <= value;
        @(posedge clk);
        limit_shadow = value;
        bit_count_we <= 1'b0;
        limits_used++;
    endtask

    // ------------------------------------------------------------------------
    // One random phase under a fixed bit_count. Most traffic is a run of sets
    // (or clears) over consecutive bits followed by a search of the opposite
    // polarity starting at or just below the run, so the scan has to step
    // over full bytes and words. The rest is single requests and noise.
    // fill_bias is the percentage of runs and single writes that set bits.
    // ------------------------------------------------------------------------
    task automatic run_phase(input logic [bfn_pkg::CNT_W-1:0] limit_value,
                             input int unsigned fill_bias, input int unsigned items);
        int unsigned sent;
        int unsigned lim;
        int unsigned pick;
        int unsigned run_len;
        int unsigned first;
        int unsigned back;
        int unsigned k;
        logic [2:0]  kind;
        logic        set_run;
        settle();
        write_limit(limit_value);
        lim  = active_limit();
        sent = 0;
        while (sent < items)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 25 && lim > 1)
            begin
                first   = $urandom_range(0, lim - 1);
                run_len = $urandom_range(4, 48);
                set_run = ($urandom_range(0, 99) < fill_bias);
                for (k = 0; k < run_len && first + k < lim; k++)
                    send_request(set_run ? bfn_pkg::REQ_SET : bfn_pkg::REQ_CLEAR,
                                 bfn_pkg::IDX_W'(first + k), BY_MODEL, '0);
                back = $urandom_range(0, 2);
                send_request(set_run ? bfn_pkg::REQ_FIND_CLEAR : bfn_pkg::REQ_FIND_SET,
                             bfn_pkg::IDX_W'((first > back) ? first - back : 0),
                             BY_MODEL, '0);
                sent += k + 1;
            end
            else if (pick >= 88)
            begin
                // any code, any index: spare codes and out-of-range accesses
                send_request(3'($urandom_range(0, 7)),
                             bfn_pkg::IDX_W'($urandom_range(0, MAP_BITS - 1)),
                             BY_MODEL, '0);
                sent++;
            end
            else
            begin
                pick = $urandom_range(0, 99);
                if (pick < 20)
                    kind = bfn_pkg::REQ_GET;
                else if (pick < 45)
                    kind = ($urandom_range(0, 99) < fill_bias) ? bfn_pkg::REQ_SET
                                                               : bfn_pkg::REQ_CLEAR;
                else if (pick < 70)
                    kind = bfn_pkg::REQ_FIND_CLEAR;
                else
                    kind = bfn_pkg::REQ_FIND_SET;
                send_request(kind, pick_index(lim), BY_MODEL, '0);
                sent++;
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // Result checker: every done cycle carries one result transaction, which
    // is matched in order against the oldest expectation.
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin : check_results
        bitmap_reply_t want;
        if (rst_n === 1'b1 && done === 1'b1)
        begin
            results_checked++;
            if (expected_replies.size() == 0)
            begin
                failures++;
                if (failures <= REPORT_LIMIT)
                    $display("unexpected result %0d: bit_value %0b found %0b found_index %0d",
                             results_checked, bit_value, found, found_index);
            end
            else
            begin
                want = expected_replies.pop_front();
                if (bit_value !== want.bit_value || found !== want.found ||
                    found_index !== want.found_index)
                begin
                    failures++;
                    if (failures <= REPORT_LIMIT)
                    begin
                        $display("result %0d: exp bit_value %0b found %0b found_index %0d",
                                 results_checked, want.bit_value, want.found,
                                 want.found_index);
                        $display("result %0d: got bit_value %0b found %0b found_index %0d",
                                 results_checked, bit_value, found, found_index);
                    end
                end
            end
        end
    end

    // Watchdog: end the run if neither side moves a transaction for too long.
    always @(posedge clk)
    begin
        if ((start === 1'b1 && busy === 1'b0) || done === 1'b1)
            stall_cycles = 0;
        else
        begin
            stall_cycles++;
            if (stall_cycles >= STALL_LIMIT)
            begin
                $display("watchdog: no transaction for %0d cycles", STALL_LIMIT);
                $display("bitmap_find_next regression: fail");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    initial
    begin
        rst_n        = 1'b0;
        start        = 1'b0;
        req_type     = bfn_pkg::REQ_GET;
        bit_index    = '0;
        bit_count_we = 1'b0;
        bit_count    = bfn_pkg::BIT_COUNT_RESET;
        map_shadow   = '0;
        limit_shadow = bfn_pkg::BIT_COUNT_RESET;
        failures        = 0;
        results_checked = 0;
        finds_located   = 0;
        limits_used     = 0;
        burst_left      = 0;
        stall_cycles    = 0;
        foreach (kind_seen[n])
            kind_seen[n] = 0;

        // Scripted part. Columns: bit_count to write first (or keep), request,
        // index, where the expectation comes from, and the typed-in reply.
        // Empty bitmap after reset, both ends of the index range.
        add_step(KEEP_LIMIT, bfn_pkg::REQ_GET,        0,    BY_TABLE, 0, 0, 0);
        add_step(KEEP_LIMIT, bfn_pkg::REQ_GET,        1023, BY_TABLE, 0, 0, 0);
        add_step(KEEP_LIMIT, bfn_pkg::REQ_FIND_CLEAR, 0,    BY_TABLE, 0, 1, 0);
        add_step(KEEP_LIMIT, bfn_pkg::REQ_FIND_CLEAR, 1023, BY_TABLE, 0, 1, 1023);
        // nothing set yet: search finds no match
        add_step(KEEP_LIMIT, bfn_pkg::REQ_FIND_SET,   0,    BY_TABLE, 0, 0, 0);
        add_step(KEEP_LIMIT, bfn_pkg::REQ_SET,        1023, BY_TABLE, 0, 0, 0);
        add_step(KEEP_LIMIT, bfn_pkg::REQ_GET,        1023, BY_TABLE, 1, 0, 0);
        add_step(KEEP_LIMIT, bfn_pkg::REQ_FIND_SET,   0,    BY_MODEL, 0, 0, 0);
        add_step(KEEP_LIMIT, bfn_pkg::REQ_SET,        0,    BY_TABLE, 0, 0, 0);
        add_step(KEEP_LIMIT, bfn_pkg::REQ_FIND_CLEAR, 0,    BY_MODEL, 0, 0, 0);
        add_step(KEEP_LIMIT, bfn_pkg::REQ_FIND_SET,   1,    BY_MODEL, 0, 0, 0);
        add_step(KEEP_LIMIT, bfn_pkg::REQ_CLEAR,      1023, BY_TABLE, 0, 0, 0);
        // spare request codes answer all zeros
        add_step(KEEP_LIMIT, REQ_SPARE_A,             1023, BY_TABLE, 0, 0, 0);
        add_step(KEEP_LIMIT, REQ_SPARE_B,             0,    BY_TABLE, 0, 0, 0);
        add_step(KEEP_LIMIT, REQ_SPARE_C,             682,  BY_TABLE, 0, 0, 0);
        // bit_count above capacity saturates to the bitmap size
        add_step(2047,       bfn_pkg::REQ_SET,        1023, BY_TABLE, 0, 0, 0);
        add_step(KEEP_LIMIT, bfn_pkg::REQ_FIND_SET,   1,    BY_MODEL, 0, 0, 0);
        // zero boundary: every access ignored, every search misses
        add_step(0,          bfn_pkg::REQ_GET,        0,    BY_TABLE, 0, 0, 0);
        add_step(KEEP_LIMIT, bfn_pkg::REQ_FIND_CLEAR, 0,    BY_TABLE, 0, 0, 0);
        add_step(KEEP_LIMIT, bfn_pkg::REQ_SET,        5,    BY_TABLE, 0, 0, 0);
        // half boundary: out-of-range write, start at the boundary
        add_step(512,        bfn_pkg::REQ_GET,        5,    BY_MODEL, 0, 0, 0);
        add_step(KEEP_LIMIT, bfn_pkg::REQ_FIND_SET,   512,  BY_TABLE, 0, 0, 0);
        add_step(KEEP_LIMIT, bfn_pkg::REQ_SET,        600,  BY_TABLE, 0, 0, 0);
        add_step(KEEP_LIMIT, bfn_pkg::REQ_FIND_SET,   1,    BY_MODEL, 0, 0, 0);
        add_step(1024,       bfn_pkg::REQ_GET,        600,  BY_MODEL, 0, 0, 0);

        // Hold reset, then wait out the clearing sweep before the first request.
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        do @(posedge clk); while (busy !== 1'b0);

        foreach (script[n])
        begin
            if (script[n].change_limit)
            begin
                settle();
                write_limit(script[n].limit_value);
            end
            send_request(script[n].kind, script[n].idx, script[n].source, script[n].reply);
        end

        // Random phases: full size, saturated, empty, single bit, one short of
        // full, one byte, two random sizes, and a dense full-size finish.
        run_phase(bfn_pkg::CNT_W'(1024), 60, 200);
        run_phase(bfn_pkg::CNT_W'(2047), 80, 180);
        run_phase(bfn_pkg::CNT_W'(0),    50, 20);
        run_phase(bfn_pkg::CNT_W'(1),    50, 40);
        run_phase(bfn_pkg::CNT_W'(1023), 90, 200);
        run_phase(bfn_pkg::CNT_W'(8),    50, 80);
        run_phase(bfn_pkg::CNT_W'($urandom_range(2, 1022)), 30, 200);
        run_phase(bfn_pkg::CNT_W'($urandom_range(2, 1022)), 70, 200);
        run_phase(bfn_pkg::CNT_W'(1024), 95, 220);

        // Drain, then give a late or extra result time to show up.
        settle();
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("covered %0d requests: %0d get, %0d set, %0d clear,",
                 kind_seen[0] + kind_seen[1] + kind_seen[2] + kind_seen[3] + kind_seen[4] +
                 kind_seen[5] + kind_seen[6] + kind_seen[7],
                 kind_seen[bfn_pkg::REQ_GET], kind_seen[bfn_pkg::REQ_SET],
                 kind_seen[bfn_pkg::REQ_CLEAR]);
        $display("  %0d find-clear, %0d find-set, %0d spare",
                 kind_seen[bfn_pkg::REQ_FIND_CLEAR], kind_seen[bfn_pkg::REQ_FIND_SET],
                 kind_seen[REQ_SPARE_A] + kind_seen[REQ_SPARE_B] + kind_seen[REQ_SPARE_C]);
        $display("%0d bit_count settings, %0d searches hit, %0d results checked, %0d failures",
                 limits_used, finds_located, results_checked, failures);
        if (failures == 0)
            $display("bitmap_find_next regression: pass");
        else
            $display("bitmap_find_next regression: fail");
        $finish;
    end

endmodule

FILE: filelist.f
rtl/bfn_pkg.sv
rtl/bfn_ram.sv
rtl/bitmap_find_next.sv
bench/bitmap_find_next_test.sv
